// ===== rtl/rms_pkg.sv =====
package rms_pkg;

    localparam int SAMPLE_WIDTH = 16;      // width of the sample field on the port
    localparam int SAMPLE_BITS  = 16;      // significant two's complement bits of a sample
    localparam int MAX_COUNT    = 65535;   // samples accumulated per session at most

    localparam int COUNT_WIDTH  = 16;
    localparam int SUM_WIDTH    = 32;
    localparam int SQSUM_WIDTH  = 48;
    localparam int PROD_WIDTH   = 64;
    localparam int ROOT_WIDTH   = 32;
    localparam int RES_WIDTH    = 16;
    localparam int OUT_WIDTH    = 56;      // 49 result bits padded to whole bytes

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

    // Take the low SAMPLE_BITS bits as a two's complement value.
    function automatic logic signed [SUM_WIDTH-1:0] sample_ext(
        input logic [SAMPLE_WIDTH-1:0] raw
    );
        logic signed [SAMPLE_BITS-1:0] s;
        s = raw[SAMPLE_BITS-1:0];
        return SUM_WIDTH'(s);
    endfunction

endpackage

// ===== rtl/rms_div.sv =====
module rms_div
    import rms_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   start,
    input  logic [SUM_WIDTH-1:0]   dividend,
    input  logic [COUNT_WIDTH-1:0] divisor,
    output div_status_t            status,
    output logic [SUM_WIDTH-1:0]   quotient
);

    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic [4:0]             cnt_reg, cnt_next;
    logic [COUNT_WIDTH-1:0] rem_reg, rem_next;
    logic [SUM_WIDTH-1:0]   quo_reg, quo_next;
    logic [COUNT_WIDTH-1:0] dvs_reg, dvs_next;

    logic [COUNT_WIDTH:0]   trial;
    logic [COUNT_WIDTH:0]   trial_sub;
    logic                   trial_ge;

    // Restoring division: one quotient bit per cycle, dividend shifts out
    // of the top of quo_reg while quotient bits shift in at the bottom.
    assign trial     = {rem_reg, quo_reg[SUM_WIDTH-1]};
    assign trial_ge  = trial >= {1'b0, dvs_reg};
    assign trial_sub = trial - {1'b0, dvs_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end else if (busy_reg) begin
            rem_next = trial_ge ? trial_sub[COUNT_WIDTH-1:0] : trial[COUNT_WIDTH-1:0];
            quo_next = {quo_reg[SUM_WIDTH-2:0], trial_ge};
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'(SUM_WIDTH - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign status   = '{busy: busy_reg, done: done_reg};
    assign quotient = quo_reg;

endmodule

// ===== rtl/running_mean_stddev.sv =====
// Running mean and population standard deviation of signed Q8.8 samples.
// Each nonzero sample beat adds to a running count, sum and sum of squares
// and yields one result beat: the mean (sum / count, truncated toward zero)
// and floor(sqrt(n*S2 - S1^2) / n), both Q8.8, with the count and a flag
// that is set once the count sits at its maximum and a sample was dropped.
// A zero sample clears the session and yields no result beat. An item runs
// in order through the square of the sample on a bit-serial shift-add
// multiplier, the sum update, the divider start, the multiplies for n*S2 and
// S1^2 on the same multiplier, the difference, a square root that takes two
// radicand bits per step and a restoring divider for the deviation (the mean
// division overlaps the multiplies), and then the loading of the output
// register once it is free; a sample taken with the count already full skips
// the square and the sum update.
// The input is taken again once the result is in the output register, so
// one result beat may wait while the next item is in work.
module running_mean_stddev
    import rms_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [SAMPLE_WIDTH-1:0] s_tdata,   // [15:0] sample
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [OUT_WIDTH-1:0]    m_tdata    // [15:0] mean_value, [31:16] std_deviation,
                                               // [47:32] sample_total, [48] count_saturated
);

    typedef enum logic [9:0] {
        ST_IDLE   = 10'b0000000001,
        ST_SQUARE = 10'b0000000010,
        ST_UPDATE = 10'b0000000100,
        ST_START  = 10'b0000001000,
        ST_MUL_A  = 10'b0000010000,
        ST_MUL_B  = 10'b0000100000,
        ST_DIFF   = 10'b0001000000,
        ST_SQRT   = 10'b0010000000,
        ST_DIV    = 10'b0100000000,
        ST_OUT    = 10'b1000000000
    } state_t;

    state_t                  state_reg, state_next;
    logic [COUNT_WIDTH-1:0]  count_reg, count_next;
    logic [SUM_WIDTH-1:0]    sum_reg, sum_next;
    logic [SQSUM_WIDTH-1:0]  sq_sum_reg, sq_sum_next;
    logic                    sat_reg, sat_next;
    logic [SUM_WIDTH-1:0]    x_reg, x_next;

    logic [PROD_WIDTH-1:0]   mul_acc_reg, mul_acc_next;
    logic [PROD_WIDTH-1:0]   mul_mcand_reg, mul_mcand_next;
    logic [SUM_WIDTH-1:0]    mul_mplier_reg, mul_mplier_next;
    logic [4:0]              step_reg, step_next;
    logic [PROD_WIDTH-1:0]   a_reg, a_next;

    logic [PROD_WIDTH-1:0]   sq_x_reg, sq_x_next;
    logic [ROOT_WIDTH+1:0]   sq_rem_reg, sq_rem_next;
    logic [ROOT_WIDTH-1:0]   sq_root_reg, sq_root_next;

    logic [RES_WIDTH-1:0]    mean_reg, mean_next;
    logic [RES_WIDTH-1:0]    sd_reg, sd_next;
    logic                    m_tvalid_reg, m_tvalid_next;
    logic [OUT_WIDTH-1:0]    m_tdata_reg, m_tdata_next;

    logic signed [SUM_WIDTH-1:0] in_x;
    logic                    in_zero;
    logic [SAMPLE_BITS:0]    in_mag;
    logic [SUM_WIDTH-1:0]    sum_mag;
    logic [PROD_WIDTH-1:0]   mul_sum;
    logic                    step_last;
    logic [ROOT_WIDTH+3:0]   sq_rem2;
    logic [ROOT_WIDTH+3:0]   sq_trial;
    logic [ROOT_WIDTH+3:0]   sq_rem_sub;
    logic                    sq_ge;
    logic [ROOT_WIDTH-1:0]   sq_root_new;
    logic [PROD_WIDTH-1:0]   diff;
    logic                    out_free;

    logic                    div_start;
    logic [SUM_WIDTH-1:0]    div_dividend;
    div_status_t             div_status;
    logic [SUM_WIDTH-1:0]    div_quotient;

    rms_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (count_reg),
        .status   (div_status),
        .quotient (div_quotient)
    );

    assign in_x      = sample_ext(s_tdata);
    assign in_zero   = (in_x == '0);
    assign in_mag    = (SAMPLE_BITS + 1)'(in_x[SUM_WIDTH-1] ? -in_x : in_x);
    assign sum_mag   = sum_reg[SUM_WIDTH-1] ? (~sum_reg + 1'b1) : sum_reg;

    assign mul_sum   = mul_acc_reg + (mul_mplier_reg[0] ? mul_mcand_reg : '0);
    assign step_last = (step_reg == '0);

    // Square root, two radicand bits per step.
    assign sq_rem2     = {sq_rem_reg, sq_x_reg[PROD_WIDTH-1 -: 2]};
    assign sq_trial    = {2'b00, sq_root_reg, 2'b01};
    assign sq_ge       = sq_rem2 >= sq_trial;
    assign sq_rem_sub  = sq_rem2 - sq_trial;
    assign sq_root_new = {sq_root_reg[ROOT_WIDTH-2:0], sq_ge};

    assign diff     = (a_reg > mul_acc_reg) ? (a_reg - mul_acc_reg) : '0;
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        sum_next        = sum_reg;
        sq_sum_next     = sq_sum_reg;
        sat_next        = sat_reg;
        x_next          = x_reg;
        mul_acc_next    = mul_acc_reg;
        mul_mcand_next  = mul_mcand_reg;
        mul_mplier_next = mul_mplier_reg;
        step_next       = step_reg;
        a_next          = a_reg;
        sq_x_next       = sq_x_reg;
        sq_rem_next     = sq_rem_reg;
        sq_root_next    = sq_root_reg;
        mean_next       = mean_reg;
        sd_next         = sd_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_tdata_next    = m_tdata_reg;
        div_start       = 1'b0;
        div_dividend    = sum_mag;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    if (in_zero) begin
                        count_next  = '0;
                        sum_next    = '0;
                        sq_sum_next = '0;
                        sat_next    = 1'b0;
                    end else if (count_reg >= COUNT_WIDTH'(MAX_COUNT)) begin
                        // drop the sample, report from the unchanged sums
                        sat_next   = 1'b1;
                        state_next = ST_START;
                    end else begin
                        x_next          = in_x;
                        mul_acc_next    = '0;
                        mul_mcand_next  = PROD_WIDTH'(in_mag);
                        mul_mplier_next = SUM_WIDTH'(in_mag);
                        step_next       = 5'(SAMPLE_BITS);
                        state_next      = ST_SQUARE;
                    end
                end
            end
            ST_SQUARE, ST_MUL_A, ST_MUL_B: begin
                mul_acc_next    = mul_sum;
                mul_mcand_next  = {mul_mcand_reg[PROD_WIDTH-2:0], 1'b0};
                mul_mplier_next = {1'b0, mul_mplier_reg[SUM_WIDTH-1:1]};
                step_next       = step_reg - 5'd1;
                if (step_last) begin
                    if (state_reg == ST_SQUARE) begin
                        state_next = ST_UPDATE;
                    end else if (state_reg == ST_MUL_A) begin
                        a_next          = mul_sum;
                        mul_acc_next    = '0;
                        mul_mcand_next  = PROD_WIDTH'(sum_mag);
                        mul_mplier_next = sum_mag;
                        step_next       = 5'(SUM_WIDTH - 1);
                        state_next      = ST_MUL_B;
                    end else begin
                        state_next = ST_DIFF;
                    end
                end
            end
            ST_UPDATE: begin
                count_next  = count_reg + 1'b1;
                sum_next    = sum_reg + x_reg;
                sq_sum_next = sq_sum_reg + mul_acc_reg[SQSUM_WIDTH-1:0];
                state_next  = ST_START;
            end
            ST_START: begin
                // mean division runs alongside the multiplies
                div_start       = 1'b1;
                div_dividend    = sum_mag;
                mul_acc_next    = '0;
                mul_mcand_next  = PROD_WIDTH'(sq_sum_reg);
                mul_mplier_next = SUM_WIDTH'(count_reg);
                step_next       = 5'(COUNT_WIDTH - 1);
                state_next      = ST_MUL_A;
            end
            ST_DIFF: begin
                sq_x_next    = diff;
                sq_rem_next  = '0;
                sq_root_next = '0;
                step_next    = 5'(ROOT_WIDTH - 1);
                state_next   = ST_SQRT;
            end
            ST_SQRT: begin
                sq_x_next    = {sq_x_reg[PROD_WIDTH-3:0], 2'b00};
                sq_rem_next  = sq_ge ? sq_rem_sub[ROOT_WIDTH+1:0] : sq_rem2[ROOT_WIDTH+1:0];
                sq_root_next = sq_root_new;
                step_next    = step_reg - 5'd1;
                if (step_last) begin
                    div_start    = 1'b1;
                    div_dividend = sq_root_new;
                    state_next   = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_status.done) begin
                    sd_next = (div_quotient > SUM_WIDTH'(16'hFFFF)) ?
                              16'hFFFF : div_quotient[RES_WIDTH-1:0];
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = OUT_WIDTH'({sat_reg, count_reg, sd_reg, mean_reg});
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // capture the mean when its division finishes
        if (div_status.done && state_reg != ST_DIV) begin
            if (!sum_reg[SUM_WIDTH-1]) begin
                mean_next = (div_quotient > SUM_WIDTH'(16'h7FFF)) ?
                            16'h7FFF : div_quotient[RES_WIDTH-1:0];
            end else begin
                mean_next = (div_quotient > SUM_WIDTH'(16'h8000)) ?
                            16'h8000 : RES_WIDTH'(~div_quotient + 1'b1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            sum_reg      <= '0;
            sq_sum_reg   <= '0;
            sat_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            sum_reg      <= sum_next;
            sq_sum_reg   <= sq_sum_next;
            sat_reg      <= sat_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        x_reg          <= x_next;
        mul_acc_reg    <= mul_acc_next;
        mul_mcand_reg  <= mul_mcand_next;
        mul_mplier_reg <= mul_mplier_next;
        step_reg       <= step_next;
        a_reg          <= a_next;
        sq_x_reg       <= sq_x_next;
        sq_rem_reg     <= sq_rem_next;
        sq_root_reg    <= sq_root_next;
        mean_reg       <= mean_next;
        sd_reg         <= sd_next;
        m_tdata_reg    <= m_tdata_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_div_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> !div_status.busy)
        else $error("divider started while busy");

    a_mean_done_before_sqrt: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SQRT) |-> !div_status.busy)
        else $error("mean division still running during square root");

    a_sat_full: assert property (@(posedge aclk) disable iff (!aresetn)
        sat_reg |-> (count_reg == COUNT_WIDTH'(MAX_COUNT)))
        else $error("saturation flag set with count below maximum");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_UPDATE) |=> (count_reg != '0))
        else $error("count wrapped on update");

endmodule
